[src/dma_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types of the dual moving average block.
package dma_pkg;

  localparam int unsigned SHORT_DEPTH_DEF = 64;
  localparam int unsigned LONG_DEPTH_DEF  = 256;

  localparam int unsigned PRICE_W     = 32;
  localparam int unsigned SHORT_LEN_W = 7;
  localparam int unsigned LONG_LEN_W  = 9;
  localparam int unsigned CFG_DATA_W  = 9;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [SHORT_LEN_W-1:0] SHORT_LEN_RESET = 7'd4;
  localparam logic [LONG_LEN_W-1:0]  LONG_LEN_RESET  = 9'd6;

  // slots in each of the input and result queues
  localparam int unsigned FIFO_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_LEN = 1'b0,
    REG_LONG_LEN  = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START,
    ST_DIVIDE
  } eng_state_e;

  typedef struct packed {
    logic clear;
    logic update;
  } win_ctrl_t;

endpackage

[src/dual_moving_average.sv]
`timescale 1ns / 1ps
// Top level of the dual moving average block.
//
// Usage: price samples (unsigned Q16.16) go in through a queue-style port: a
// sample transfers on a clock edge with push high and full low. Each sample
// yields one result holding the short and long window averages, read from a
// queue-style port: the oldest result sits on the outputs while empty is low
// and transfers on an edge with pop high.
// Window lengths are written through cfg_we_i / cfg_index_i / cfg_data_i while
// the block is idle; any write to a length clears that window and its sum.
// Flow: a two-entry input queue feeds a sequencer that pops a sample, updates
// both windows, then runs two bit-serial dividers side by side. Each sample
// passes through the sequencer as pop, update, divider load, 32 divide steps
// and a final result write; the sequencer takes no new sample until that
// divide loop is through, and that loop sets the throughput.
// Reset clears windows, sums and queues and loads lengths 4 and 6; the windows
// read as zero until filled, with no clearing pass. When the receiver stalls,
// the two-entry result queue fills, the sequencer waits, and then the input
// queue fills and raises full.
module dual_moving_average import dma_pkg::*; #(
  parameter int unsigned SHORT_DEPTH = SHORT_DEPTH_DEF,
  parameter int unsigned LONG_DEPTH  = LONG_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  logic [PRICE_W-1:0]    price_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [PRICE_W-1:0]    short_average_o,
  output logic [PRICE_W-1:0]    long_average_o
);

  localparam int unsigned S_IDX_W = (SHORT_DEPTH > 1) ? $clog2(SHORT_DEPTH) : 1;
  localparam int unsigned L_IDX_W = (LONG_DEPTH > 1) ? $clog2(LONG_DEPTH) : 1;
  localparam int unsigned S_LEN_W = $clog2(SHORT_DEPTH + 1);
  localparam int unsigned L_LEN_W = $clog2(LONG_DEPTH + 1);
  // a window sum needs the sample width plus one bit per doubling of depth
  localparam int unsigned S_SUM_W = PRICE_W + S_IDX_W;
  localparam int unsigned L_SUM_W = PRICE_W + L_IDX_W;
  localparam int unsigned RES_W   = 2 * PRICE_W;

  eng_state_e           state_q, state_d;
  logic                 in_empty, in_pop;
  logic [PRICE_W-1:0]   in_price;
  logic [PRICE_W-1:0]   price_q;
  logic                 out_full, out_push;
  logic [RES_W-1:0]     out_data;
  win_ctrl_t            s_ctrl, l_ctrl;
  logic                 s_clear, l_clear, upd;
  logic [S_SUM_W-1:0]   s_sum;
  logic [L_SUM_W-1:0]   l_sum;
  logic [S_LEN_W-1:0]   s_len;
  logic [L_LEN_W-1:0]   l_len;
  logic                 div_start, s_busy, l_busy;
  logic [PRICE_W-1:0]   s_quo, l_quo;

  // ---------------- front: input queue ----------------
  dma_fifo #(.W(PRICE_W)) u_in_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (price_i),
    .full_o  (full),
    .pop_i   (in_pop),
    .data_o  (in_price),
    .empty_o (in_empty)
  );

  // ---------------- configuration decode ----------------
  always_comb begin
    s_clear = 1'b0;
    l_clear = 1'b0;
    unique case (cfg_reg_e'(cfg_index_i))
      REG_SHORT_LEN: s_clear = cfg_we_i;
      REG_LONG_LEN:  l_clear = cfg_we_i;
      default: ;
    endcase
  end

  // ---------------- back: sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (!in_empty && !out_full) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_START;
      ST_START:  state_d = ST_DIVIDE;
      ST_DIVIDE: if (!s_busy && !l_busy) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // one item in flight at a time, so a free result slot at pop time stays free
  always_comb begin
    in_pop    = 1'b0;
    upd       = 1'b0;
    div_start = 1'b0;
    out_push  = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_pop    = !in_empty && !out_full;
      ST_UPDATE: upd       = 1'b1;
      ST_START:  div_start = 1'b1;
      ST_DIVIDE: out_push  = !s_busy && !l_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_pop) begin
      price_q <= in_price;
    end
  end

  assign s_ctrl = '{clear: s_clear, update: upd};
  assign l_ctrl = '{clear: l_clear, update: upd};

  // the windows read their slot during the pop cycle and write it back on update
  dma_window #(
    .DEPTH     (SHORT_DEPTH),
    .LEN_REG_W (SHORT_LEN_W),
    .LEN_RESET (SHORT_LEN_RESET),
    .IDX_W     (S_IDX_W),
    .LEN_W     (S_LEN_W),
    .SUM_W     (S_SUM_W)
  ) u_short_win (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (s_ctrl),
    .len_data_i (cfg_data_i[SHORT_LEN_W-1:0]),
    .price_i    (price_q),
    .sum_o      (s_sum),
    .len_o      (s_len)
  );

  dma_window #(
    .DEPTH     (LONG_DEPTH),
    .LEN_REG_W (LONG_LEN_W),
    .LEN_RESET (LONG_LEN_RESET),
    .IDX_W     (L_IDX_W),
    .LEN_W     (L_LEN_W),
    .SUM_W     (L_SUM_W)
  ) u_long_win (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (l_ctrl),
    .len_data_i (cfg_data_i[LONG_LEN_W-1:0]),
    .price_i    (price_q),
    .sum_o      (l_sum),
    .len_o      (l_len)
  );

  dma_divider #(.LEN_W(S_LEN_W), .SUM_W(S_SUM_W)) u_short_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (s_sum),
    .divisor_i  (s_len),
    .busy_o     (s_busy),
    .quotient_o (s_quo)
  );

  dma_divider #(.LEN_W(L_LEN_W), .SUM_W(L_SUM_W)) u_long_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (l_sum),
    .divisor_i  (l_len),
    .busy_o     (l_busy),
    .quotient_o (l_quo)
  );

  // ---------------- result queue ----------------
  dma_fifo #(.W(RES_W)) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  ({s_quo, l_quo}),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_data),
    .empty_o (empty)
  );

  assign short_average_o = out_data[RES_W-1:PRICE_W];
  assign long_average_o  = out_data[PRICE_W-1:0];

endmodule

[src/dma_fifo.sv]
`timescale 1ns / 1ps
// Small register queue used on the input and on the result side.
module dma_fifo import dma_pkg::*; #(
  parameter int unsigned W = PRICE_W
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  logic [W-1:0]  slot_q [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          wr_en, rd_en;

  assign full_o  = (count_q == CW'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + CW'(1);
    end else if (rd_en && !wr_en) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[src/dma_window.sv]
`timescale 1ns / 1ps
// One sliding window: sample memory, running sum, write position and fill count.
module dma_window import dma_pkg::*; #(
  parameter int unsigned             DEPTH     = SHORT_DEPTH_DEF,
  parameter int unsigned             LEN_REG_W = SHORT_LEN_W,
  parameter logic [LEN_REG_W-1:0]    LEN_RESET = SHORT_LEN_RESET,
  parameter int unsigned             IDX_W     = 6,
  parameter int unsigned             LEN_W     = 7,
  parameter int unsigned             SUM_W     = 38
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  win_ctrl_t            ctrl_i,
  input  logic [LEN_REG_W-1:0] len_data_i,
  input  logic [PRICE_W-1:0]   price_i,
  output logic [SUM_W-1:0]     sum_o,
  output logic [LEN_W-1:0]     len_o
);

  localparam logic [31:0] DEPTH_V = 32'(DEPTH);

  logic [PRICE_W-1:0]   mem_q [DEPTH];
  logic [PRICE_W-1:0]   rd_q;
  logic [LEN_REG_W-1:0] len_reg_q;
  logic [LEN_W-1:0]     len_eff;
  logic [IDX_W-1:0]     pos_q, pos_d;
  logic [LEN_W-1:0]     fill_q, fill_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [PRICE_W-1:0]   leaving;
  logic [LEN_W-1:0]     pos_inc;

  // zero acts as one, anything past the memory saturates at its depth
  always_comb begin
    if (len_reg_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(len_reg_q) > DEPTH_V) begin
      len_eff = LEN_W'(DEPTH);
    end else begin
      len_eff = LEN_W'(len_reg_q);
    end
  end

  // slots are written in order from zero, so a slot below the fill count is live
  assign leaving = (fill_q > LEN_W'(pos_q)) ? rd_q : '0;
  assign pos_inc = LEN_W'(pos_q) + LEN_W'(1);

  always_comb begin
    sum_d  = sum_q;
    pos_d  = pos_q;
    fill_d = fill_q;
    if (ctrl_i.update) begin
      sum_d  = sum_q - SUM_W'(leaving) + SUM_W'(price_i);
      pos_d  = (pos_inc >= len_eff) ? '0 : IDX_W'(pos_inc);
      fill_d = (fill_q < len_eff) ? fill_q + LEN_W'(1) : fill_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_reg_q <= LEN_RESET;
      sum_q     <= '0;
      pos_q     <= '0;
      fill_q    <= '0;
    end else if (ctrl_i.clear) begin
      len_reg_q <= len_data_i;
      sum_q     <= '0;
      pos_q     <= '0;
      fill_q    <= '0;
    end else begin
      sum_q     <= sum_d;
      pos_q     <= pos_d;
      fill_q    <= fill_d;
    end
  end

  // read the slot under the write position every cycle; the registered value is used in the next cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.update) begin
      mem_q[pos_q] <= price_i;
    end
    rd_q <= mem_q[pos_q];
  end

  assign sum_o = sum_q;
  assign len_o = len_eff;

endmodule

[src/dma_divider.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 32-bit quotient.
module dma_divider import dma_pkg::*; #(
  parameter int unsigned LEN_W = 7,
  parameter int unsigned SUM_W = 38
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SUM_W-1:0]   dividend_i,
  input  logic [LEN_W-1:0]   divisor_i,
  output logic               busy_o,
  output logic [PRICE_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(PRICE_W);

  logic               busy_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [LEN_W-1:0]   rem_q;
  logic [LEN_W-1:0]   divisor_q;
  logic [PRICE_W-1:0] quo_q;
  logic [LEN_W:0]     trial;
  logic [LEN_W:0]     diff;
  logic               fits;

  // sum < len * 2^32, so the bits above 32 are already a valid partial remainder
  assign trial = {rem_q, quo_q[PRICE_W-1]};
  assign fits  = (trial >= {1'b0, divisor_q});
  assign diff  = trial - {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(PRICE_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= LEN_W'(dividend_i[SUM_W-1:PRICE_W]);
      quo_q     <= dividend_i[PRICE_W-1:0];
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      quo_q <= {quo_q[PRICE_W-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

[src/dma_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the dual moving average block, bound to the top level.
module dma_checker import dma_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               pop,
  input logic               empty,
  input logic [PRICE_W-1:0] short_average_o,
  input logic [PRICE_W-1:0] long_average_o
);

  // input queue plus result queue: the sequencer only takes a sample while the
  // result queue has a free slot, so it never adds a slot of its own
  localparam int unsigned CAP   = 2 * FIFO_DEPTH;
  localparam int unsigned OCC_W = $clog2(CAP + 1);

  logic [OCC_W-1:0] occ_q;
  logic             in_xfer, out_xfer;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      occ_q <= occ_q + OCC_W'(1);
    end else if (out_xfer && !in_xfer) begin
      occ_q <= occ_q - OCC_W'(1);
    end
  end

  a_no_phantom_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == '0) |-> empty)
    else $error("result offered with no sample outstanding");

  a_full_at_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == OCC_W'(CAP)) |-> full)
    else $error("input not back-pressured with every slot occupied");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((occ_q == '0) && in_xfer) |=> empty)
    else $error("result appeared one cycle after a sample transfer");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(short_average_o)
                          && $stable(long_average_o)))
    else $error("stalled result changed or vanished");

endmodule

bind dual_moving_average dma_checker u_dma_checker (.*);

[tb/tb_dual_moving_average.sv]
`timescale 1ns / 1ps
// Testbench for dual_moving_average: window tracker class, queue drivers, checks.
module tb_dual_moving_average;
  import dma_pkg::*;

  localparam int unsigned SHORT_DEPTH = SHORT_DEPTH_DEF;
  localparam int unsigned LONG_DEPTH  = LONG_DEPTH_DEF;
  localparam int unsigned SAMPLE_LATENCY = 48;
  localparam int unsigned RANDOM_SAMPLES = 1130;
  localparam int unsigned MAX_REPORTED   = 10;

  // warm-up samples at the reset lengths (4 and 6): extremes and a few odd values
  localparam logic [PRICE_W-1:0] WARMUP_PRICES [10] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h0001_0000
  };

  typedef struct packed {
    logic [PRICE_W-1:0] short_avg;
    logic [PRICE_W-1:0] long_avg;
  } avg_pair_t;

  // Tracks both price windows and holds the averages still owed by the block.
  // Index 0 is the short window, index 1 the long one.
  class window_tracker;
    logic [PRICE_W-1:0] win [2][LONG_DEPTH];
    logic [39:0]        sum [2];
    int unsigned        pos [2];
    int unsigned        len_reg [2];
    int unsigned        depth [2];
    avg_pair_t          owed_averages [$];
    int unsigned        mismatches;
    int unsigned        results_checked;

    function new();
      depth[0]   = SHORT_DEPTH;
      depth[1]   = LONG_DEPTH;
      len_reg[0] = SHORT_LEN_RESET;
      len_reg[1] = LONG_LEN_RESET;
      mismatches = 0;
      results_checked = 0;
      clear_window(0);
      clear_window(1);
    endfunction

    function void clear_window(int w);
      for (int i = 0; i < LONG_DEPTH; i++) win[w][i] = '0;
      sum[w] = '0;
      pos[w] = 0;
    endfunction

    function int unsigned active_length(int w);
      if (len_reg[w] == 0) return 1;
      if (len_reg[w] > depth[w]) return depth[w];
      return len_reg[w];
    endfunction

    // any write clears its window, even with an unchanged value
    function void write_length(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SHORT_LEN: begin
          len_reg[0] = data[SHORT_LEN_W-1:0];
          clear_window(0);
        end
        REG_LONG_LEN: begin
          len_reg[1] = data[LONG_LEN_W-1:0];
          clear_window(1);
        end
        default: ;
      endcase
    endfunction

    function logic [PRICE_W-1:0] slide(int w, logic [PRICE_W-1:0] price);
      int unsigned        n;
      int unsigned        p;
      logic [PRICE_W-1:0] leaving;
      logic [39:0]        quotient;
      n = active_length(w);
      p = pos[w];
      if (p >= n || p >= depth[w]) p = 0;
      leaving   = win[w][p];
      win[w][p] = price;
      sum[w]    = sum[w] - {8'd0, leaving} + {8'd0, price};
      p++;
      if (p >= n) p = 0;
      pos[w]   = p;
      quotient = sum[w] / 40'(n);
      return quotient[PRICE_W-1:0];
    endfunction

    function void take_price(logic [PRICE_W-1:0] price);
      avg_pair_t next;
      next.short_avg = slide(0, price);
      next.long_avg  = slide(1, price);
      owed_averages.push_back(next);
    endfunction

    function void flag(string what, logic [PRICE_W-1:0] want, logic [PRICE_W-1:0] got);
      if (mismatches < MAX_REPORTED)
        $display("[%0t] %s mismatch: expected %h, got %h", $realtime, what, want, got);
      mismatches++;
    endfunction

    function void check_averages(logic [PRICE_W-1:0] s_avg, logic [PRICE_W-1:0] l_avg);
      avg_pair_t want;
      results_checked++;
      if (owed_averages.size() == 0) begin
        if (mismatches < MAX_REPORTED)
          $display("[%0t] result with nothing owed: short %h long %h",
                   $realtime, s_avg, l_avg);
        mismatches++;
        return;
      end
      want = owed_averages.pop_front();
      if (want.short_avg !== s_avg) flag("short_average", want.short_avg, s_avg);
      if (want.long_avg !== l_avg) flag("long_average", want.long_avg, l_avg);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  push;
  logic                  full;
  logic [PRICE_W-1:0]    price_i;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [PRICE_W-1:0]    short_average_o;
  logic [PRICE_W-1:0]    long_average_o;

  window_tracker tracker;
  int unsigned   samples_sent = 0;
  int unsigned   settings_used;
  int unsigned   pop_cycle = 0;
  int unsigned   pop_mode = 0;

  dual_moving_average #(
    .SHORT_DEPTH(SHORT_DEPTH),
    .LONG_DEPTH (LONG_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .price_i        (price_i),
    .empty          (empty),
    .pop            (pop),
    .short_average_o(short_average_o),
    .long_average_o (long_average_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Monitor: everything is sampled at the edge, before the NBAs of that edge land,
  // so a transfer is seen exactly as the block sees it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) tracker.write_length(cfg_reg_e'(cfg_index_i), cfg_data_i);
      if (push && !full) begin
        tracker.take_price(price_i);
        samples_sent++;
      end
      if (pop && !empty) tracker.check_averages(short_average_o, long_average_o);
    end
  end

  // Receiver: periodically switches to a randomly picked stall style.
  //   0: always ready, 1: coin flip, 2: ready one cycle in eight,
  //   3: long stall then a short run of pops (fills both queues, backs up full)
  always @(posedge clk_i) begin
    pop_cycle++;
    if (pop_cycle % 300 == 0) pop_mode <= $urandom_range(0, 3);
    case (pop_mode)
      0: pop <= 1'b1;
      1: pop <= 1'($urandom_range(0, 1));
      2: pop <= ($urandom_range(0, 7) == 0);
      default: pop <= ((pop_cycle % 80) < 6);
    endcase
  end

  // Holds push high until the transfer edge; push stays high on return so
  // back-to-back samples need no re-raise.
  task automatic send_price(input logic [PRICE_W-1:0] p);
    push    <= 1'b1;
    price_i <= p;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic hold_off(input int unsigned cycles);
    if (cycles > 0) begin
      push <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Stops the sender until every owed result has come out, then lets the
  // sequencer settle so a length write lands on an idle block.
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (tracker.owed_averages.size() != 0) @(posedge clk_i);
    repeat (SAMPLE_LATENCY) @(posedge clk_i);
  endtask

  // one write, with cfg_we_i dropped again before the task returns so back-to-back writes never collide
  task automatic program_length(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [PRICE_W-1:0] pick_price();
    case ($urandom_range(0, 7))
      0: return 32'($urandom_range(0, 16'hFFFF));                    // below 1.0
      1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 16'hFFFF));    // near max
      2: return 32'h1 << $urandom_range(0, 31);                      // one hot
      3: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
      4, 5: return 32'h0064_0000 + 32'($urandom_range(0, 20'hFFFFF)); // 100.0 to under 116.0
      default: return $urandom();
    endcase
  endfunction

  // Length values: in range mostly, plus zero, the depth edge and raw 9-bit
  // values that exercise masking and saturation.
  function automatic logic [CFG_DATA_W-1:0] pick_length(input int unsigned depth);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 9'd1;
      2: return 9'(depth);
      3, 4: return 9'($urandom_range(0, 511));
      default: return 9'($urandom_range(1, depth));
    endcase
  endfunction

  // Sender bursts of random length with random gaps; max_gap of zero gives
  // a stretch with no idling at all.
  task automatic send_random(input int unsigned count, input int unsigned max_gap);
    int unsigned burst;
    burst = $urandom_range(1, 16);
    for (int i = 0; i < count; i++) begin
      send_price(pick_price());
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 16);
        hold_off($urandom_range(0, max_gap));
      end
    end
  endtask

  initial begin
    int unsigned left;
    int unsigned count;
    int unsigned long_now;
    push        = 1'b0;
    price_i     = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_SHORT_LEN;
    cfg_data_i  = '0;
    settings_used = 1;
    tracker = new();
    rst_ni  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // warm-up at reset lengths: zeros counted in, then full-scale sums
    foreach (WARMUP_PRICES[i]) send_price(WARMUP_PRICES[i]);
    drain_results();

    // zero length acts as one sample
    program_length(REG_SHORT_LEN, 9'd0);
    program_length(REG_LONG_LEN, 9'd0);
    settings_used++;
    send_price(32'hFFFF_FFFF);
    hold_off(2);
    send_price(32'h1234_5678);
    send_price(32'h0000_0000);
    drain_results();

    // all-ones data: short masks to 127, both saturate to their depth
    program_length(REG_SHORT_LEN, 9'h1FF);
    program_length(REG_LONG_LEN, 9'h1FF);
    settings_used++;
    repeat (4) send_price(32'hFFFF_FFFF);
    drain_results();

    // random phases, each behind a full drain so lengths change on an idle block
    left = RANDOM_SAMPLES;
    while (left > 0) begin
      case ($urandom_range(0, 3))
        0: ;  // keep the windows running across the pause
        1: program_length(REG_SHORT_LEN, pick_length(SHORT_DEPTH));
        default: begin
          program_length(REG_SHORT_LEN, pick_length(SHORT_DEPTH));
          program_length(REG_LONG_LEN, pick_length(LONG_DEPTH));
        end
      endcase
      settings_used++;
      long_now = tracker.active_length(1);
      // long windows sometimes get enough samples to wrap
      if (long_now > 64 && $urandom_range(0, 2) == 0)
        count = long_now + $urandom_range(10, 60);
      else
        count = $urandom_range(15, 80);
      if (count > left) count = left;
      send_random(count, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 20));
      left -= count;
      drain_results();
    end

    $display("covered %0d samples over %0d window settings, %0d results checked",
             samples_sent, settings_used, tracker.results_checked);
    if (tracker.mismatches == 0 && tracker.owed_averages.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", tracker.mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // safety net: a clean run needs well under a fifth of this
  initial begin
    #(8_000_000);
    $display("timeout with %0d results still owed", tracker.owed_averages.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
